>>> hdl/tree_parent_contraction_unit_macros.svh
// Assertion macros shared by the contraction unit.
`ifndef TREE_PARENT_CONTRACTION_UNIT_MACROS_SVH
`define TREE_PARENT_CONTRACTION_UNIT_MACROS_SVH

// Same-cycle implication under reset.
`define TPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tpc assertion failed");

// Next-cycle implication under reset.
`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tpc assertion failed");

`endif

>>> hdl/tpc_pkg.sv
// Types and constants of the tree parent contraction unit.
package tpc_pkg;

	localparam int NODE_BITS   = 10;
	localparam int TABLE_DEPTH = 1024;
	localparam int MAX_NODES   = 1024;
	localparam int SIZE_BITS   = 24;
	localparam int STEP_BITS   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_LOAD,
		OP_QUERY
	} op_t;

	typedef struct packed {
		logic        mode;
		logic [9:0]  node;
		logic [9:0]  parent;
		logic        has_parent;
		logic [23:0] set_size;
	} req_t;

	typedef struct packed {
		logic [9:0] queried_node;
		logic [9:0] contracted_parent;
		logic       has_contracted;
		logic       walk_error;
	} rsp_t;

	typedef struct packed {
		logic                 has_parent;
		logic [NODE_BITS-1:0] parent;
	} link_t;

	typedef struct packed {
		op_t                  op;
		logic [NODE_BITS-1:0] node;
		link_t                link;
		logic [SIZE_BITS-1:0] size;
	} entry_t;

endpackage

>>> hdl/tree_parent_contraction_unit.sv
// Usage notes:
// Forest lookup unit. The req channel takes one word per accepted edge
// (req_valid high, req_stall low). A load word (mode 0) writes a node's
// parent link and set size and produces no response. A query word (mode 1)
// walks from the node towards its root and returns the farthest ancestor
// whose size is at most twice the node's size, else the direct parent; a root gets none.
// Words go through a four-deep queue, so req_stall rises only when it fills.
// A word is registered in the queue before the walker can take it. A load
// is written from the queue head while the walker idles. A query passes a
// head state, a walk over its ancestors (at most MAX_NODES) and a finish
// state that registers its response. The walker reads one ancestor per cycle from
// the node tables, which sets the rate. The response register lets the
// walker start the next word while a result waits; if rsp_stall stays high
// the walker holds its finished result and the queue then backs up to req.
// Reset clears the queue, walker and response valid; the node tables hold
// no reset value and must be loaded before nodes are queried.
`include "tree_parent_contraction_unit_macros.svh"

module tree_parent_contraction_unit import tpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;

	tpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_entry   (q_entry)
	);

	tpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop       (q_pop),
		.q_entry   (q_entry),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// a root never reports a cycle
	`TPC_ASSERT_NOW(a_root_no_err, clk, arst_n, rsp_valid && !rsp.has_contracted, !rsp.walk_error)
	`TPC_ASSERT_NOW(a_root_zero, clk, arst_n, rsp_valid && !rsp.has_contracted,
		rsp.contracted_parent == '0)
	// a pop of a nonempty queue frees a slot, so req cannot stay stalled
	`TPC_ASSERT_NEXT(a_pop_frees, clk, arst_n, q_pop && q_valid && req_stall, !req_stall)

endmodule

>>> hdl/tpc_front.sv
// Front end: classifies incoming words and queues them for the walker.
module tpc_front import tpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_stall,
	input  req_t   req,
	input  logic   pop,
	output logic   q_valid,
	output entry_t q_entry
);

	entry_t               queue_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	entry_t               cls;
	logic [31:0]          size_ext;
	logic                 push;
	logic                 take;

	always_comb begin
		size_ext = 32'(req.set_size);
		cls.op = req.mode ? OP_QUERY : OP_LOAD;
		cls.node = req.node;
		// a root stores parent 0 with the valid bit clear
		cls.link.has_parent = req.has_parent;
		cls.link.parent = req.has_parent ? req.parent : '0;
		cls.size = size_ext[SIZE_BITS-1:0];
	end

	assign req_stall = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign push = req_valid && !req_stall;
	assign q_valid = (cnt_q != '0);
	assign take = pop && q_valid;
	assign q_entry = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, take})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/tpc_back.sv
// Back end: node tables, ancestor walker and result register.
module tpc_back import tpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	output logic   pop,
	input  entry_t q_entry,
	output logic   rsp_valid,
	input  logic   rsp_stall,
	output rsp_t   rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_WALK,
		ST_FIN
	} state_t;

	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(MAX_NODES - 1);

	link_t                link_mem [TABLE_DEPTH];
	logic [SIZE_BITS-1:0] size_mem [TABLE_DEPTH];

	state_t               state_q;
	link_t                rd_link_q;
	logic [SIZE_BITS-1:0] rd_size_q;
	logic [SIZE_BITS:0]   limit_q;
	logic [NODE_BITS-1:0] node_q;
	logic [NODE_BITS-1:0] cur_q;
	logic [NODE_BITS-1:0] choice_q;
	logic                 has_q;
	logic                 err_q;
	logic [STEP_BITS-1:0] steps_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 rd_en;
	logic [NODE_BITS-1:0] rd_addr;
	logic                 wr_en;
	logic                 go_on;
	logic                 out_free;

	assign pop = (state_q == ST_IDLE);
	assign wr_en = pop && q_valid && (q_entry.op == OP_LOAD);
	assign go_on = rd_link_q.has_parent && (steps_q != STEP_LAST);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = rd_link_q.parent;
		case (state_q)
			ST_IDLE: begin
				rd_en = q_valid && (q_entry.op == OP_QUERY);
				rd_addr = q_entry.node;
			end
			ST_HEAD: rd_en = rd_link_q.has_parent;
			ST_WALK: rd_en = go_on;
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[q_entry.node] <= q_entry.link;
			size_mem[q_entry.node] <= q_entry.size;
		end
		if (rd_en) begin
			rd_link_q <= link_mem[rd_addr];
			rd_size_q <= size_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_entry.op == OP_QUERY) begin
						node_q <= q_entry.node;
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (rd_link_q.has_parent) begin
						limit_q <= {rd_size_q, 1'b0};
						cur_q <= rd_link_q.parent;
						choice_q <= rd_link_q.parent;
						has_q <= 1'b1;
						err_q <= 1'b0;
						steps_q <= '0;
						state_q <= ST_WALK;
					end else begin
						choice_q <= '0;
						has_q <= 1'b0;
						err_q <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_WALK: begin
					if ({1'b0, rd_size_q} <= limit_q) begin
						choice_q <= cur_q;
					end
					if (go_on) begin
						cur_q <= rd_link_q.parent;
						steps_q <= steps_q + 1'b1;
					end else begin
						// still linked after the last allowed step: cyclic table
						err_q <= rd_link_q.has_parent;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						rsp_q.queried_node <= node_q;
						rsp_q.contracted_parent <= choice_q;
						rsp_q.has_contracted <= has_q;
						rsp_q.walk_error <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> bench/testbench.sv
// Self-checking bench for the tree parent contraction unit: loads, queries, cycles, back-pressure.
`timescale 1ns / 1ps

import tpc_pkg::*;

class contraction_scoreboard;
	link_t                links [TABLE_DEPTH];
	logic [SIZE_BITS-1:0] sizes [TABLE_DEPTH];
	rsp_t                 pending_answers [$];
	int                   errors;
	int                   checked;
	int                   loads;
	int                   queries;
	int                   cyclic_walks;

	function new();
		foreach (links[i]) begin
			links[i] = '0;
			sizes[i] = '0;
		end
		errors       = 0;
		checked      = 0;
		loads        = 0;
		queries      = 0;
		cyclic_walks = 0;
	endfunction

	// farthest ancestor within twice the node's size, else the direct parent
	function rsp_t contract_parent(logic [NODE_BITS-1:0] start);
		rsp_t                 r;
		link_t                hop;
		logic [NODE_BITS-1:0] cur;
		logic [SIZE_BITS:0]   bound;
		int                   steps;
		r = '0;
		r.queried_node = start;
		hop = links[start];
		if (hop.has_parent) begin
			bound = {sizes[start], 1'b0};
			cur = hop.parent;
			r.contracted_parent = cur;
			r.has_contracted = 1'b1;
			steps = 0;
			forever begin
				if ({1'b0, sizes[cur]} <= bound)
					r.contracted_parent = cur;
				steps++;
				hop = links[cur];
				if (!hop.has_parent)
					break;
				if (steps >= MAX_NODES) begin
					r.walk_error = 1'b1;
					break;
				end
				cur = hop.parent;
			end
		end
		return r;
	endfunction

	function void note_word(req_t w);
		if (w.mode == OP_LOAD) begin
			if (w.has_parent) begin
				links[w.node].has_parent = 1'b1;
				links[w.node].parent     = w.parent;
			end else begin
				links[w.node] = '0;
			end
			sizes[w.node] = w.set_size;
			loads++;
		end else begin
			pending_answers = {pending_answers, contract_parent(w.node)};
			queries++;
		end
	endfunction

	function void check_answer(rsp_t got);
		rsp_t want;
		if (pending_answers.size() == 0) begin
			$error("result for node %0d with no query waiting", got.queried_node);
			errors++;
			return;
		end
		want = pending_answers.pop_front();
		checked++;
		if (want.walk_error)
			cyclic_walks++;
		if (got.queried_node !== want.queried_node) begin
			$error("queried_node: expected %0d, actual %0d", want.queried_node,
				got.queried_node);
			errors++;
		end
		if (got.contracted_parent !== want.contracted_parent) begin
			$error("contracted_parent: expected %0d, actual %0d", want.contracted_parent,
				got.contracted_parent);
			errors++;
		end
		if (got.has_contracted !== want.has_contracted) begin
			$error("has_contracted: expected %0d, actual %0d", want.has_contracted,
				got.has_contracted);
			errors++;
		end
		if (got.walk_error !== want.walk_error) begin
			$error("walk_error: expected %0d, actual %0d", want.walk_error,
				got.walk_error);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int IDLE_LIMIT    = 20000;
	localparam int DRAIN_CYCLES  = MAX_NODES + 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_WORDS  = 560;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	contraction_scoreboard sb = new();

	// sender-side view of which nodes are loaded; queries only go to these
	bit gen_loaded [TABLE_DEPTH];
	int loaded_list [$];
	int last_node = -1;
	int send_calm = 0;
	int take_calm = 0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;

	tree_parent_contraction_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// runs of zero gaps now and then, otherwise a random idle gap
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	task automatic send_word(req_t w);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic load_node(int n, int p, bit hp, int sz);
		req_t w;
		w            = '0;
		w.mode       = OP_LOAD;
		w.node       = n[NODE_BITS-1:0];
		w.parent     = p[NODE_BITS-1:0];
		w.has_parent = hp;
		w.set_size   = sz[23:0];
		send_word(w);
		if (!gen_loaded[n]) begin
			gen_loaded[n] = 1'b1;
			loaded_list = {loaded_list, n};
		end
		last_node = n;
	endtask

	// load fields carry junk; the block must ignore them
	task automatic query_node(int n);
		req_t w;
		w            = '0;
		w.mode       = OP_QUERY;
		w.node       = n[NODE_BITS-1:0];
		w.parent     = NODE_BITS'($urandom_range(0, 1023));
		w.has_parent = 1'($urandom_range(0, 1));
		w.set_size   = 24'($urandom);
		send_word(w);
	endtask

	// parents always point at loaded nodes, so every walk stays on loaded entries
	task automatic random_load();
		int n;
		int p;
		int sz;
		int pick;
		bit hp;
		pick = $urandom_range(0, 99);
		if (pick < 90 && loaded_list.size() < TABLE_DEPTH) begin
			do n = $urandom_range(0, 1023); while (gen_loaded[n]);
		end else begin
			n = $urandom_range(0, 1023);
		end
		pick = $urandom_range(0, 99);
		p = $urandom_range(0, 1023);
		hp = 1'b1;
		if (loaded_list.size() == 0 || pick < 15)
			hp = 1'b0;
		else if (pick < 55)
			p = last_node;
		else
			p = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
		case ($urandom_range(0, 3))
			0: sz = $urandom_range(0, 64);
			1: sz = $urandom & 32'hFF_FFFF;
			2: sz = $urandom_range(0, 1) ? 32'hFF_FFFF : 0;
			default: sz = $urandom_range(0, 4096);
		endcase
		load_node(n, p, hp, sz);
	endtask

	task automatic wait_all_answered();
		@(posedge clk);
		while (sb.pending_answers.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_word(req);
			if (rsp_valid && !rsp_stall)
				sb.check_answer(rsp);
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin : answer_side
		int gap;
		rsp_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			// one long hold so the queue backs up into req_stall
			if (!hold_done && sb.checked >= 60) begin
				hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = draw_gap(take_calm);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	initial begin : request_side
		req_valid <= 1'b0;
		req       <= '0;
		arst_n    <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, fallback to direct parent, root, boundary size, cycles
		load_node(1023, 1023, 1'b0, 32'hFF_FFFF);
		load_node(2, 1023, 1'b1, 100);
		load_node(0, 2, 1'b1, 0);
		query_node(0);
		query_node(1023);
		load_node(8, 511, 1'b0, 30);
		load_node(7, 8, 1'b1, 20);
		load_node(6, 7, 1'b1, 25);
		load_node(5, 6, 1'b1, 10);
		query_node(5);
		query_node(6);
		load_node(9, 8, 1'b1, 15);
		query_node(9);
		load_node(10, 1023, 1'b1, 32'hFF_FFFF);
		query_node(10);
		load_node(21, 8, 1'b1, 5);
		load_node(20, 21, 1'b1, 5);
		load_node(21, 20, 1'b1, 5);
		query_node(20);
		load_node(30, 30, 1'b1, 7);
		query_node(30);
		query_node(7);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2) begin
				req_valid <= 1'b0;
				wait_all_answered();
			end
			if (loaded_list.size() == 0 || $urandom_range(0, 99) < 45)
				random_load();
			else
				query_node(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
		end
		req_valid <= 1'b0;

		wait_all_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d loads and %0d queries, %0d results checked",
			sb.loads, sb.queries, sb.checked);
		$display("%0d cyclic walks, one long receiver hold, one full drain mid-run",
			sb.cyclic_walks);
		if (sb.errors == 0 && sb.pending_answers.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
